### hdl/nq_pkg.sv
// nq_pkg: sizes, controller states and the command/status structs of the
// N-queens first-solution search. No dependencies.
`timescale 1ns / 1ps

package nq_pkg;

	localparam int MAX_SIZE     = 16;
	localparam int RESULT_LIMIT = 16;
	localparam int SIZE_LIMIT   = (MAX_SIZE < RESULT_LIMIT) ? MAX_SIZE : RESULT_LIMIT;

	localparam int IN_W   = 5;                      // board_size field
	localparam int OUT_W  = 4;                      // column / queen_row fields
	localparam int ROW_W  = $clog2(MAX_SIZE);       // row or column index
	localparam int CNT_W  = $clog2(MAX_SIZE + 1);   // count up to MAX_SIZE
	localparam int DIAG_N = 2 * MAX_SIZE - 1;
	localparam int DIAG_W = $clog2(DIAG_N);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TRY,
		ST_BACK,
		ST_OUT_RD,
		ST_OUT_LD,
		ST_NOTFOUND
	} nq_state_t;

	typedef struct packed {
		logic load;      // capture N, clear masks and column
		logic place;     // mark candidate square, push row, next column
		logic skip;      // next candidate row
		logic back_rd;   // step back one column, read its row
		logic back_fix;  // unmark popped queen, resume at row + 1
		logic k_clr;     // restart result index
		logic out_rd;    // read row of result index
		logic out_ld;    // load result item, advance index
		logic nf_ld;     // load the no-solution item
	} nq_cmd_t;

	typedef struct packed {
		logic n_ok;      // N within 1..SIZE_LIMIT
		logic col_done;  // all columns placed
		logic row_end;   // candidate row ran past N-1
		logic col_zero;  // at first column
		logic free;      // candidate square not attacked
		logic out_free;  // output register can take an item
		logic k_last;    // result index at column N-1
	} nq_status_t;

endpackage

### hdl/nq_ctrl.sv
// nq_ctrl: sequencer of the depth-first search and of result delivery.
// Depends on nq_pkg.
`timescale 1ns / 1ps

module nq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  nq_pkg::nq_status_t sts,
	output nq_pkg::nq_cmd_t    cmd
);
	import nq_pkg::*;

	nq_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_TRY;
				end
			end
			ST_TRY: begin
				if (!sts.n_ok) begin
					state_d = ST_NOTFOUND;
				end else if (sts.col_done) begin
					cmd.k_clr = 1'b1;
					state_d   = ST_OUT_RD;
				end else if (!sts.row_end) begin
					if (sts.free) cmd.place = 1'b1;
					else cmd.skip = 1'b1;
				end else if (sts.col_zero) begin
					state_d = ST_NOTFOUND;
				end else begin
					cmd.back_rd = 1'b1;
					state_d     = ST_BACK;
				end
			end
			ST_BACK: begin
				cmd.back_fix = 1'b1;
				state_d      = ST_TRY;
			end
			ST_OUT_RD: begin
				cmd.out_rd = 1'b1;
				state_d    = ST_OUT_LD;
			end
			ST_OUT_LD: begin
				if (sts.out_free) begin
					cmd.out_ld = 1'b1;
					state_d    = sts.k_last ? ST_IDLE : ST_OUT_RD;
				end
			end
			ST_NOTFOUND: begin
				if (sts.out_free) begin
					cmd.nf_ld = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

### hdl/nq_datapath.sv
// nq_datapath: occupancy masks, row stack memory, column/row counters and
// the output register. Depends on nq_pkg.
`timescale 1ns / 1ps

module nq_datapath (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [nq_pkg::IN_W-1:0]  board_size,
	input  nq_pkg::nq_cmd_t          cmd,
	output nq_pkg::nq_status_t       sts,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [nq_pkg::OUT_W-1:0] column,
	output logic [nq_pkg::OUT_W-1:0] queen_row,
	output logic                     found,
	output logic                     last
);
	import nq_pkg::*;

	function automatic logic [DIAG_W-1:0] down_idx(input logic [ROW_W-1:0] r,
			input logic [ROW_W-1:0] c);
		logic [DIAG_W:0] s;
		s = (DIAG_W + 1)'(r) + (DIAG_W + 1)'(MAX_SIZE - 1) - (DIAG_W + 1)'(c);
		return s[DIAG_W-1:0];
	endfunction

	function automatic logic [DIAG_W-1:0] up_idx(input logic [ROW_W-1:0] r,
			input logic [ROW_W-1:0] c);
		logic [DIAG_W:0] s;
		s = (DIAG_W + 1)'(r) + (DIAG_W + 1)'(c);
		return s[DIAG_W-1:0];
	endfunction

	logic [IN_W-1:0]     n_q;
	logic [CNT_W-1:0]    col_q;
	logic [CNT_W-1:0]    row_q;
	logic [ROW_W-1:0]    k_q;
	logic [MAX_SIZE-1:0] rows_q;
	logic [DIAG_N-1:0]   down_q;
	logic [DIAG_N-1:0]   up_q;

	logic [ROW_W-1:0]    stack_mem [MAX_SIZE];
	logic [ROW_W-1:0]    rd_data_q;
	logic [ROW_W-1:0]    rd_addr;
	logic [CNT_W-1:0]    col_dec;
	logic [CNT_W-1:0]    n_cnt;
	logic [ROW_W-1:0]    col_idx;
	logic [ROW_W-1:0]    row_idx;
	logic                out_valid_q;

	assign n_cnt   = CNT_W'(n_q);
	assign col_idx = col_q[ROW_W-1:0];
	assign row_idx = row_q[ROW_W-1:0];
	assign col_dec = col_q - CNT_W'(1);
	assign rd_addr = cmd.back_rd ? col_dec[ROW_W-1:0] : k_q;

	assign sts.n_ok     = (n_q != '0) && (n_q <= IN_W'(SIZE_LIMIT));
	assign sts.col_done = (col_q >= n_cnt);
	assign sts.row_end  = (row_q >= n_cnt);
	assign sts.col_zero = (col_q == '0);
	assign sts.free     = !rows_q[row_idx] && !down_q[down_idx(row_idx, col_idx)]
		&& !up_q[up_idx(row_idx, col_idx)];
	assign sts.out_free = !out_valid_q || !out_stall;
	assign sts.k_last   = (CNT_W'(k_q) + CNT_W'(1)) == n_cnt;

	// row stack: written on a placement, read on backtrack or result delivery
	always_ff @(posedge clk) begin
		if (cmd.place) begin
			stack_mem[col_idx] <= row_idx;
		end
		if (cmd.back_rd || cmd.out_rd) begin
			rd_data_q <= stack_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			rows_q <= '0;
			down_q <= '0;
			up_q   <= '0;
		end else if (cmd.load) begin
			col_q  <= '0;
			row_q  <= '0;
			rows_q <= '0;
			down_q <= '0;
			up_q   <= '0;
		end else if (cmd.place) begin
			rows_q[row_idx]                   <= 1'b1;
			down_q[down_idx(row_idx, col_idx)] <= 1'b1;
			up_q[up_idx(row_idx, col_idx)]     <= 1'b1;
			col_q                             <= col_q + CNT_W'(1);
			row_q                             <= '0;
		end else if (cmd.skip) begin
			row_q <= row_q + CNT_W'(1);
		end else if (cmd.back_rd) begin
			col_q <= col_dec;
		end else if (cmd.back_fix) begin
			rows_q[rd_data_q]                    <= 1'b0;
			down_q[down_idx(rd_data_q, col_idx)] <= 1'b0;
			up_q[up_idx(rd_data_q, col_idx)]     <= 1'b0;
			row_q                                <= CNT_W'(rd_data_q) + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q <= board_size;
		end
		if (cmd.k_clr) begin
			k_q <= '0;
		end else if (cmd.out_ld) begin
			k_q <= k_q + ROW_W'(1);
		end
		if (cmd.out_ld) begin
			column    <= OUT_W'(k_q);
			queen_row <= OUT_W'(rd_data_q);
			found     <= 1'b1;
			last      <= sts.k_last;
		end else if (cmd.nf_ld) begin
			column    <= '0;
			queen_row <= '0;
			found     <= 1'b0;
			last      <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_ld || cmd.nf_ld) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

### hdl/n_queens_first_solution.sv
// n_queens_first_solution: top level, controller plus datapath.
// Depends on nq_pkg, nq_ctrl, nq_datapath.
//
// Usage:
//  Input channel (in_valid / in_stall / board_size) takes one request: a
//  board size N. in_stall is high from the accepted request until the
//  last result item of that search has been loaded into the output register.
//  Output channel (out_valid / out_stall) returns N items column 0..N-1 with
//  the queen's row, found = 1 and last on column N-1; or, for N of zero,
//  two, three or above the size limit, one item with found = 0, last = 1,
//  column and queen_row 0.
//  Sequence: each tried square is one search step; a backtrack step passes
//  through ST_TRY and ST_BACK (the popped row comes from the stack memory's
//  registered read port), and each result item through ST_OUT_RD and
//  ST_OUT_LD, which waits while the receiver stalls. The search length is
//  set by the backtracking loop. One search runs at a time.
//  A stall on the output holds the output register; the search already done
//  waits, and a new request may be taken while the final item still waits.
//  Reset (arst_n low, asynchronous) returns to idle and empties the output
//  register; the row stack needs no clearing since each search writes an
//  entry before it reads it.
`timescale 1ns / 1ps

module n_queens_first_solution (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [nq_pkg::IN_W-1:0]  board_size,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [nq_pkg::OUT_W-1:0] column,
	output logic [nq_pkg::OUT_W-1:0] queen_row,
	output logic                     found,
	output logic                     last
);
	import nq_pkg::*;

	nq_cmd_t    cmd;
	nq_status_t sts;

	// sequencer: one search step or one delivery step per cycle; delivery waits while the output stalls
	nq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// masks, stack and output register
	nq_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.board_size (board_size),
		.cmd        (cmd),
		.sts        (sts),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.column     (column),
		.queen_row  (queen_row),
		.found      (found),
		.last       (last)
	);

endmodule

### hdl/nq_checker.sv
// nq_checker: port-level checks of the search block, bound to the top level.
// Depends on nq_pkg and n_queens_first_solution.
`timescale 1ns / 1ps

module nq_checker (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_stall,
	input logic [nq_pkg::IN_W-1:0]  board_size,
	input logic                     out_valid,
	input logic                     out_stall,
	input logic [nq_pkg::OUT_W-1:0] column,
	input logic [nq_pkg::OUT_W-1:0] queen_row,
	input logic                     found,
	input logic                     last
);
	import nq_pkg::*;

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(column) && $stable(queen_row)
			&& $stable(found) && $stable(last))
		else $error("stalled result changed");

	// no-solution item is a single, zeroed item
	a_nf_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> last && column == '0 && queen_row == '0)
		else $error("malformed no-solution item");

	// a taken request keeps the input closed while the search runs
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken while busy");

	// mid-solution, no new request is taken
	a_mid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> in_stall)
		else $error("request taken before last result");

endmodule

bind n_queens_first_solution nq_checker u_nq_checker (.*);

### tb/sv/n_queens_first_solution_tb.sv
// n_queens_first_solution_tb: self-checking bench for the N-queens first-solution search.
// Depends on nq_pkg and n_queens_first_solution. A built-in solver predicts every reply.
`timescale 1ns / 1ps

module n_queens_first_solution_tb;

	import nq_pkg::*;

	// one reply item as the block presents it
	typedef struct packed {
		logic [OUT_W-1:0] column;
		logic [OUT_W-1:0] queen_row;
		logic             found;
		logic             last;
	} placement_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic [IN_W-1:0]  board_size = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [OUT_W-1:0] column;
	logic [OUT_W-1:0] queen_row;
	logic             found;
	logic             last;

	// replies still owed by the block, oldest first
	placement_t  queen_placements[$];
	int unsigned error_count = 0;

	// idle odds in percent: sender gaps and receiver stalls
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;

	n_queens_first_solution dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.board_size (board_size),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.column     (column),
		.queen_row  (queen_row),
		.found      (found),
		.last       (last)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// receiver backpressure, redrawn every cycle
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	task automatic report_mismatch(input string msg);
		// keep the log short on a badly broken build, but count everything
		if (error_count < 100)
			$display("[%0t] MISMATCH: %s", $time, msg);
		error_count++;
	endtask

	// Depth-first search for the first non-attacking placement, columns left
	// to right, rows ascending, backing up one column on a dead end.
	// Queues the reply items that one request of size n must produce.
	function automatic void solve_first_placement(input logic [IN_W-1:0] n);
		bit [MAX_SIZE-1:0]   row_busy;
		bit [2*MAX_SIZE-2:0] down_busy;   // indexed row - col + MAX_SIZE - 1
		bit [2*MAX_SIZE-2:0] up_busy;     // indexed row + col
		int                  chosen[MAX_SIZE];
		int                  size;
		int                  col;
		int                  r;
		int                  start;
		bit                  searching;
		bit                  solved;
		bit                  placed;
		placement_t          item;
		size = n;
		solved = 1'b0;
		// zero, and anything past the size limit, never starts a search
		if (size >= 1 && size <= SIZE_LIMIT) begin
			row_busy = '0;
			down_busy = '0;
			up_busy = '0;
			col = 0;
			start = 0;
			searching = 1'b1;
			while (searching) begin
				if (col >= size) begin
					solved = 1'b1;
					searching = 1'b0;
				end else begin
					placed = 1'b0;
					for (r = start; r < size && !placed; r++) begin
						if (!row_busy[r] && !down_busy[r - col + MAX_SIZE - 1] &&
								!up_busy[r + col]) begin
							row_busy[r] = 1'b1;
							down_busy[r - col + MAX_SIZE - 1] = 1'b1;
							up_busy[r + col] = 1'b1;
							chosen[col] = r;
							col++;
							start = 0;
							placed = 1'b1;
						end
					end
					if (!placed) begin
						// dead end in column 0 means no placement at all (sizes two, three)
						if (col == 0) begin
							searching = 1'b0;
						end else begin
							col--;
							r = chosen[col];
							row_busy[r] = 1'b0;
							down_busy[r - col + MAX_SIZE - 1] = 1'b0;
							up_busy[r + col] = 1'b0;
							start = r + 1;
						end
					end
				end
			end
		end
		if (solved) begin
			for (int k = 0; k < size; k++) begin
				item.column = k[OUT_W-1:0];
				item.queen_row = chosen[k][OUT_W-1:0];
				item.found = 1'b1;
				item.last = (k == size - 1);
				queen_placements.push_back(item);
			end
		end else begin
			// single not-found item, column and row held at zero
			item = '0;
			item.last = 1'b1;
			queen_placements.push_back(item);
		end
	endfunction

	// Present one request. Called just after a rising edge; returns just after
	// the edge that took it, with in_valid still high so that a back-to-back
	// request needs no second assignment in the same step.
	task automatic send_board(input logic [IN_W-1:0] n);
		bit taken;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		board_size <= n;
		// decide acceptance from mid-cycle values, which are settled
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
		solve_first_placement(n);
	endtask

	task automatic idle_requests();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_all_replies();
		while (queen_placements.size() != 0)
			@(posedge clk);
	endtask

	// every size up to the limit and the one just past it, plus sizes past it
	// with all bits set and a mid value
	task automatic test_edge_sizes();
		for (int s = 0; s <= 17; s++)
			send_board(s[IN_W-1:0]);
		send_board(5'd24);
		send_board(5'd31);
	endtask

	// a request arriving only after the block has gone fully quiet
	task automatic test_drained_start();
		logic [IN_W-1:0] sizes[3];
		sizes[0] = 5'd8;
		sizes[1] = 5'd2;
		sizes[2] = 5'd1;
		foreach (sizes[i]) begin
			idle_requests();
			wait_all_replies();
			send_board(sizes[i]);
		end
	endtask

	// mostly small boards, a few of the slow mid sizes, some out of range;
	// sixteen stays in the directed part since its search is by far the longest
	task automatic test_random_sizes(input int count);
		logic [IN_W-1:0] n;
		int unsigned     pick;
		repeat (count) begin
			pick = $urandom_range(99);
			if (pick < 78)
				n = IN_W'($urandom_range(12));
			else if (pick < 88)
				n = IN_W'($urandom_range(15, 13));
			else
				n = IN_W'($urandom_range(31, 17));
			send_board(n);
		end
	endtask

	// Reply checker: an item is taken at the edge after a mid-cycle sample
	// with valid high and stall low; compare against the oldest prediction.
	always @(negedge clk) begin
		placement_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (queen_placements.size() == 0) begin
				report_mismatch($sformatf("unrequested reply col=%0d row=%0d found=%0b last=%0b",
					column, queen_row, found, last));
			end else begin
				want = queen_placements.pop_front();
				if (column !== want.column)
					report_mismatch($sformatf("column got %0d want %0d", column, want.column));
				if (queen_row !== want.queen_row)
					report_mismatch($sformatf("queen_row got %0d want %0d (col %0d)",
						queen_row, want.queen_row, want.column));
				if (found !== want.found)
					report_mismatch($sformatf("found got %0b want %0b", found, want.found));
				if (last !== want.last)
					report_mismatch($sformatf("last got %0b want %0b (col %0d)",
						last, want.last, want.column));
			end
		end
	end

	// Main sequence: reset, directed sizes, quiet start, then three random
	// phases with the idle odds swapped and finally removed.
	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 35;
		recv_stall_pct = 75;
		test_edge_sizes();
		test_drained_start();
		test_random_sizes(27);

		send_idle_pct = 75;
		recv_stall_pct = 35;
		test_random_sizes(27);

		send_idle_pct = 0;
		recv_stall_pct = 0;
		test_random_sizes(27);

		idle_requests();
		wait_all_replies();
		// tail: anything arriving now is unrequested
		repeat (200) @(posedge clk);
		if (error_count == 0)
			$display("n_queens_first_solution_tb: clean");
		else
			$display("n_queens_first_solution_tb: errors");
		$finish;
	end

	// watchdog: several times the slowest expected run
	initial begin
		#60_000_000;
		$display("n_queens_first_solution_tb: errors");
		$finish;
	end

endmodule
